@@ src/bfm_pkg.sv @@
// bfm_pkg: shared opcodes, status codes, item kinds and the command/status
// structs that join the brainfuck machine controller and datapath
// no dependencies
`default_nettype none

package bfm_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_FEED  = 2'd2;
    localparam logic [1:0] KIND_STEP  = 2'd3;

    // program opcodes
    localparam logic [2:0] OP_RIGHT = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_INC   = 3'd2;
    localparam logic [2:0] OP_DEC   = 3'd3;
    localparam logic [2:0] OP_OUT   = 3'd4;
    localparam logic [2:0] OP_IN    = 3'd5;
    localparam logic [2:0] OP_OPEN  = 3'd6;
    localparam logic [2:0] OP_CLOSE = 3'd7;

    // run status codes
    localparam logic [2:0] STAT_RUN       = 3'd0;
    localparam logic [2:0] STAT_HALT      = 3'd1;
    localparam logic [2:0] STAT_OVER      = 3'd2;
    localparam logic [2:0] STAT_UNDER     = 3'd3;
    localparam logic [2:0] STAT_UNCLOSED  = 3'd4;
    localparam logic [2:0] STAT_NEST      = 3'd5;
    localparam logic [2:0] STAT_UNMATCHED = 3'd6;

    // value stored by ',' on an empty input queue
    localparam logic [7:0] EOF_BYTE = 8'hFF;

    // reset value of the nesting limit register
    localparam logic [7:0] NEST_RESET = 8'd100;

    // controller to datapath commands
    typedef struct packed {
        logic clr_init;   // restart the machine registers and the data store sweep
        logic clr_step;   // zero one data cell
        logic load;       // append i_symbol to the program
        logic feed;       // queue i_in_byte
        logic exec;       // run the fetched instruction
        logic scan_a;     // advance the forward scan pointer
        logic scan_b;     // inspect the scanned opcode
        logic push;       // move the result into the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;   // sweep is at the last cell
        logic scan_go;    // fetched '[' on a zero cell
        logic scan_stop;  // scan ran past the end of the program
        logic scan_match; // scan found the matching ']'
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

@@ src/bfm_ctrl.sv @@
// bfm_ctrl: sequencer of the brainfuck machine (clear sweep, item decode,
// execute, forward bracket scan, result hand-off); uses bfm_pkg
`default_nettype none

module bfm_ctrl
    import bfm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic [1:0] i_kind,
    output logic            o_s_tready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCAN_A = 3'd3;
    localparam logic [2:0] S_SCAN_B = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc) begin
                    case (i_kind)
                        KIND_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_state        = S_CLR;
                        end
                        KIND_LOAD: o_cmd.load = 1'b1;
                        KIND_FEED: o_cmd.feed = 1'b1;
                        KIND_STEP: n_state = S_EXEC;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.scan_go ? S_SCAN_A : S_PUSH;
            end
            S_SCAN_A: begin
                o_cmd.scan_a = 1'b1;
                n_state      = i_sts.scan_stop ? S_PUSH : S_SCAN_B;
            end
            S_SCAN_B: begin
                o_cmd.scan_b = 1'b1;
                n_state      = i_sts.scan_match ? S_PUSH : S_SCAN_A;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register, reset starts the data store sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/bfm_dp.sv @@
// bfm_dp: brainfuck machine datapath with program, data, loop stack and
// input queue memories, machine registers and the output register; uses bfm_pkg
`default_nettype none

module bfm_dp
    import bfm_pkg::*;
#(
    parameter int DATA_DEPTH  = 32768,
    parameter int PROG_DEPTH  = 32768,
    parameter int STACK_DEPTH = 128,
    parameter int INPUT_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [2:0]  i_symbol,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,
    output logic             o_m_tuser
);

    localparam int DP_W  = $clog2(DATA_DEPTH);
    localparam int PA_W  = $clog2(PROG_DEPTH);
    localparam int PC_W  = $clog2(PROG_DEPTH + 1);
    localparam int SI_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LC_W  = $clog2(STACK_DEPTH + 1);
    localparam int QI_W  = $clog2(INPUT_DEPTH);
    localparam int QC_W  = $clog2(INPUT_DEPTH + 1);
    localparam int CMP_W = (LC_W > 8) ? LC_W : 8;

    localparam logic [DP_W-1:0]  DP_LAST   = DP_W'(DATA_DEPTH - 1);
    localparam logic [PC_W-1:0]  PROG_FULL = PC_W'(PROG_DEPTH);
    localparam logic [QI_W-1:0]  Q_LAST    = QI_W'(INPUT_DEPTH - 1);
    localparam logic [QC_W-1:0]  Q_FULL    = QC_W'(INPUT_DEPTH);
    localparam logic [CMP_W-1:0] STK_MAX   = CMP_W'(STACK_DEPTH);

    // memories
    logic [2:0]      r_prog_mem  [PROG_DEPTH];
    logic [7:0]      r_data_mem  [DATA_DEPTH];
    logic [PC_W-1:0] r_stack_mem [STACK_DEPTH];
    logic [7:0]      r_queue_mem [INPUT_DEPTH];

    logic [2:0]      r_prog_rd;
    logic [7:0]      r_data_rd;
    logic [PC_W-1:0] r_stack_rd;
    logic [7:0]      r_queue_rd;

    // machine registers
    logic [PC_W-1:0] r_pc, n_pc;
    logic [PC_W-1:0] r_len, n_len;
    logic [DP_W-1:0] r_dp, n_dp;
    logic [LC_W-1:0] r_lc, n_lc;
    logic [QI_W-1:0] r_qhead, n_qhead;
    logic [QI_W-1:0] r_qtail, n_qtail;
    logic [QC_W-1:0] r_qcnt, n_qcnt;
    logic [2:0]      r_status, n_status;
    logic [7:0]      r_cell0, n_cell0;
    logic [DP_W-1:0] r_clr_cnt, n_clr_cnt;
    logic [7:0]      r_nest;
    logic [PC_W-1:0] r_scan, n_scan;
    logic [PC_W-1:0] r_depth, n_depth;
    logic            r_ov, n_ov;
    logic [7:0]      r_ob, n_ob;

    // output register
    logic            r_mvalid;
    logic [23:0]     r_mdata;
    logic            r_muser;

    // combinational helpers
    logic            w_live;
    logic            w_err;
    logic            w_adv;
    logic [PC_W-1:0] w_pc_base;
    logic [PC_W-1:0] w_pc_nx;
    logic [PC_W-1:0] w_scan_nx;
    logic [LC_W-1:0] w_lc_dec;
    logic [CMP_W-1:0] w_limit;
    logic            w_den;
    logic [DP_W-1:0] w_daddr;
    logic [7:0]      w_ddata;
    logic            w_pen;
    logic            w_sen;
    logic            w_qen;
    logic [PA_W-1:0] w_paddr;
    logic            w_out_free;

    assign w_live    = (r_status == STAT_RUN) && (r_pc < r_len);
    assign w_scan_nx = r_scan + PC_W'(1);
    assign w_lc_dec  = r_lc - LC_W'(1);
    assign w_limit   = (CMP_W'(r_nest) < STK_MAX) ? CMP_W'(r_nest) : STK_MAX;
    assign w_paddr   = i_cmd.scan_a ? w_scan_nx[PA_W-1:0] : r_pc[PA_W-1:0];
    assign w_out_free = !r_mvalid || i_m_tready;

    // status to the controller
    always_comb begin
        o_sts.clr_done   = (r_clr_cnt == DP_LAST);
        o_sts.scan_go    = w_live && (r_prog_rd == OP_OPEN) && (r_data_rd == 8'd0);
        o_sts.scan_stop  = (w_scan_nx >= r_len);
        o_sts.scan_match = (r_prog_rd == OP_CLOSE) && (r_depth == PC_W'(1));
        o_sts.out_free   = w_out_free;
    end

    // next machine state
    always_comb begin
        n_pc      = r_pc;
        n_len     = r_len;
        n_dp      = r_dp;
        n_lc      = r_lc;
        n_qhead   = r_qhead;
        n_qtail   = r_qtail;
        n_qcnt    = r_qcnt;
        n_status  = r_status;
        n_cell0   = r_cell0;
        n_clr_cnt = r_clr_cnt;
        n_scan    = r_scan;
        n_depth   = r_depth;
        n_ov      = r_ov;
        n_ob      = r_ob;
        w_err     = 1'b0;
        w_adv     = 1'b0;
        w_pc_base = r_pc;
        w_pc_nx   = r_pc + PC_W'(1);
        w_den     = 1'b0;
        w_daddr   = r_dp;
        w_ddata   = r_data_rd;
        w_pen     = 1'b0;
        w_sen     = 1'b0;
        w_qen     = 1'b0;

        // clear item restarts pointers, counters, queue, status and the sweep
        if (i_cmd.clr_init) begin
            n_pc      = '0;
            n_len     = '0;
            n_dp      = '0;
            n_lc      = '0;
            n_qhead   = '0;
            n_qtail   = '0;
            n_qcnt    = '0;
            n_status  = STAT_RUN;
            n_cell0   = 8'd0;
            n_clr_cnt = '0;
        end

        // data store sweep, one cell a cycle
        if (i_cmd.clr_step) begin
            w_den     = 1'b1;
            w_daddr   = r_clr_cnt;
            w_ddata   = 8'd0;
            n_clr_cnt = r_clr_cnt + DP_W'(1);
        end

        // program load, ignored when full
        if (i_cmd.load && (r_len < PROG_FULL)) begin
            w_pen = 1'b1;
            n_len = r_len + PC_W'(1);
        end

        // input byte, dropped when the queue is full
        if (i_cmd.feed && (r_qcnt < Q_FULL)) begin
            w_qen   = 1'b1;
            n_qtail = (r_qtail == Q_LAST) ? '0 : r_qtail + QI_W'(1);
            n_qcnt  = r_qcnt + QC_W'(1);
        end

        // one instruction
        if (i_cmd.exec) begin
            n_ov = 1'b0;
            n_ob = 8'd0;
            if (w_live) begin
                w_adv = 1'b1;
                case (r_prog_rd)
                    OP_RIGHT: begin
                        if (r_dp == DP_LAST) w_err = 1'b1;
                        else n_dp = r_dp + DP_W'(1);
                        if (r_dp == DP_LAST) n_status = STAT_OVER;
                    end
                    OP_LEFT: begin
                        if (r_dp == '0) begin
                            w_err    = 1'b1;
                            n_status = STAT_UNDER;
                        end else begin
                            n_dp = r_dp - DP_W'(1);
                        end
                    end
                    OP_INC: begin
                        w_den   = 1'b1;
                        w_ddata = r_data_rd + 8'd1;
                    end
                    OP_DEC: begin
                        w_den   = 1'b1;
                        w_ddata = r_data_rd - 8'd1;
                    end
                    OP_OUT: begin
                        n_ov = 1'b1;
                        n_ob = r_data_rd;
                    end
                    OP_IN: begin
                        w_den = 1'b1;
                        if (r_qcnt != '0) begin
                            w_ddata = r_queue_rd;
                            n_qhead = (r_qhead == Q_LAST) ? '0 : r_qhead + QI_W'(1);
                            n_qcnt  = r_qcnt - QC_W'(1);
                        end else begin
                            w_ddata = EOF_BYTE;
                        end
                    end
                    OP_OPEN: begin
                        if (r_data_rd == 8'd0) begin
                            // forward scan takes over the pc update
                            w_adv   = 1'b0;
                            n_scan  = r_pc;
                            n_depth = PC_W'(1);
                        end else if (CMP_W'(r_lc) >= w_limit) begin
                            w_err    = 1'b1;
                            n_status = STAT_NEST;
                        end else begin
                            w_sen = 1'b1;
                            n_lc  = r_lc + LC_W'(1);
                        end
                    end
                    OP_CLOSE: begin
                        if (r_lc == '0) begin
                            w_err    = 1'b1;
                            n_status = STAT_UNMATCHED;
                        end else if (r_data_rd != 8'd0) begin
                            w_pc_base = r_stack_rd;
                        end else begin
                            n_lc = w_lc_dec;
                        end
                    end
                    default: w_err = 1'b1;
                endcase
                // advance and halt at the end of the program
                w_pc_nx = w_pc_base + PC_W'(1);
                if (w_adv && !w_err) begin
                    n_pc = w_pc_nx;
                    if (w_pc_nx >= r_len) n_status = STAT_HALT;
                end
            end else if (r_status == STAT_RUN) begin
                n_status = STAT_HALT;
            end
        end

        // scan: step the pointer, stop past the end
        if (i_cmd.scan_a) begin
            if (w_scan_nx >= r_len) n_status = STAT_UNCLOSED;
            else n_scan = w_scan_nx;
        end

        // scan: track depth, land after the matching close
        if (i_cmd.scan_b) begin
            case (r_prog_rd)
                OP_OPEN:  n_depth = r_depth + PC_W'(1);
                OP_CLOSE: begin
                    n_depth = r_depth - PC_W'(1);
                    if (r_depth == PC_W'(1)) begin
                        n_pc = w_scan_nx;
                        if (w_scan_nx >= r_len) n_status = STAT_HALT;
                    end
                end
                default: n_depth = r_depth;
            endcase
        end

        // shadow of cell 0 for the final value
        if (w_den && (w_daddr == '0)) n_cell0 = w_ddata;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_len     <= '0;
            r_dp      <= '0;
            r_lc      <= '0;
            r_qhead   <= '0;
            r_qtail   <= '0;
            r_qcnt    <= '0;
            r_status  <= STAT_RUN;
            r_cell0   <= 8'd0;
            r_clr_cnt <= '0;
            r_nest    <= NEST_RESET;
            r_mvalid  <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_len     <= n_len;
            r_dp      <= n_dp;
            r_lc      <= n_lc;
            r_qhead   <= n_qhead;
            r_qtail   <= n_qtail;
            r_qcnt    <= n_qcnt;
            r_status  <= n_status;
            r_cell0   <= n_cell0;
            r_clr_cnt <= n_clr_cnt;
            if (i_cfg_we) r_nest <= i_cfg_data;
            if (i_cmd.push && w_out_free) r_mvalid <= 1'b1;
            else if (i_m_tready) r_mvalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_depth <= n_depth;
        r_ov    <= n_ov;
        r_ob    <= n_ob;
        if (i_cmd.push && w_out_free) begin
            r_muser <= r_ov;
            r_mdata <= {5'd0, (r_status == STAT_HALT) ? r_cell0 : 8'd0, r_status, r_ob};
        end
    end

    // program store
    always_ff @(posedge i_clk) begin
        if (w_pen) r_prog_mem[r_len[PA_W-1:0]] <= i_symbol;
        r_prog_rd <= r_prog_mem[w_paddr];
    end

    // data store
    always_ff @(posedge i_clk) begin
        if (w_den) r_data_mem[w_daddr] <= w_ddata;
        r_data_rd <= r_data_mem[r_dp];
    end

    // loop stack, read port always at the top entry
    always_ff @(posedge i_clk) begin
        if (w_sen) r_stack_mem[r_lc[SI_W-1:0]] <= r_pc;
        r_stack_rd <= r_stack_mem[w_lc_dec[SI_W-1:0]];
    end

    // input queue
    always_ff @(posedge i_clk) begin
        if (w_qen) r_queue_mem[r_qtail] <= i_in_byte;
        r_queue_rd <= r_queue_mem[r_qhead];
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

    // halt and error codes stay until a clear item
    a_status_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != STAT_RUN && !i_cmd.clr_init) |=> (r_status == $past(r_status)))
        else $error("run status changed without a clear");

    // a running machine never has its pc past the program end
    a_pc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == STAT_RUN) |-> (r_pc <= r_len))
        else $error("pc beyond program length while running");

    // a stopped machine leaves pointer and loop depth alone on a step
    a_stopped_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_status != STAT_RUN) |=> ($stable(r_dp) && $stable(r_lc)))
        else $error("step changed state after a halt");

    // loop stack depth stays within the storage
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_sen) |-> (CMP_W'(r_lc) < STK_MAX))
        else $error("loop stack push beyond its depth");

endmodule

`default_nettype wire

@@ src/brainfuck_machine_step_top.sv @@
// brainfuck_machine_step_top: stream wrapper of the brainfuck machine,
// ties bfm_ctrl and bfm_dp together; uses bfm_pkg
//
// Input items arrive on the s_ stream: s_tuser holds the item kind (clear,
// load opcode, feed byte, step); s_tdata holds the opcode and the input byte.
// Load and feed items give no result. A step item runs one instruction and
// gives one result via the execute and push states; s_tready stays low until
// the result is pushed. A '[' on a zero cell scans forward through the program
// store, stepping the scan pointer and inspecting the opcode, one program
// store read each, per opcode passed. A clear item and reset both start a
// sweep zeroing every data store cell, during which s_tready stays low. The
// nesting limit is written on the cfg channel, which is always ready; write
// it only while the machine is idle (the block does not enforce this).
// Results wait in an output register: while the receiver stalls, the next item
// is still accepted, but its result is held and the input stalls till it frees.
`default_nettype none

module brainfuck_machine_step_top
    import bfm_pkg::*;
#(
    parameter int DATA_DEPTH  = 32768,
    parameter int PROG_DEPTH  = 32768,
    parameter int STACK_DEPTH = 128,
    parameter int INPUT_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [2:0] symbol, [10:3] in_byte, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [10:8] status,
                                        // [18:11] final_value, rest zero
    output logic             m_tuser,   // [0] out_valid
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data // nest_limit
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    bfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_kind     (s_tuser),
        .o_s_tready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // stores and registers
    bfm_dp #(
        .DATA_DEPTH  (DATA_DEPTH),
        .PROG_DEPTH  (PROG_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .INPUT_DEPTH (INPUT_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_symbol   (s_tdata[2:0]),
        .i_in_byte  (s_tdata[10:3]),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
